### hdl/assert_macros.svh
// Assertion macros used by the RTL of the LED pattern sequencer.
// ASSERT_ALWAYS checks a condition at every clock edge out of reset.
// ASSERT_IMPL checks that a condition implies another in the same cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants of the LED pattern sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int NUM_LEDS   = 8;
  localparam int PWM_LEVELS = 4;
  localparam int HALF_LEDS  = NUM_LEDS / 2;

  localparam int POS_W  = 3;
  localparam int PWM_W  = 3;
  localparam int MASK_W = 8;
  localparam int CNT_W  = 8;

  localparam logic [MASK_W-1:0] LED_ALL = 8'hFF;
  localparam logic [MASK_W-1:0] LED_OFF = 8'h00;
  localparam logic [CNT_W-1:0]  CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    MODE_CHASE   = 2'd0,
    MODE_BOUNCE  = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_BREATHE = 2'd3
  } mode_e;

  // Register indexes (byte address bit 2)
  localparam logic REG_DEBOUNCE_THRESHOLD = 1'b0;
  localparam logic REG_START_MODE         = 1'b1;

  localparam logic [7:0] THRESHOLD_RESET  = 8'd3;
  localparam mode_e      START_MODE_RESET = MODE_CHASE;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              dir_right;
    mode_e             mode;
    logic [PWM_W-1:0]  pwm;
    logic [CNT_W-1:0]  low_cnt;
    logic              latched;
    logic [MASK_W-1:0] led;
  } state_t;

  localparam state_t STATE_RESET = '{
    position:  '0,
    dir_right: 1'b1,
    mode:      START_MODE_RESET,
    pwm:       '0,
    low_cnt:   '0,
    latched:   1'b0,
    led:       '0
  };

endpackage

`default_nettype wire

### hdl/led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// A result is registered in the output register, or in the skid entry while one waits.
// Throughput: one item per cycle while the skid entry is free; the step logic is a single registered pass.
// Output register plus one skid entry: a second item is taken while a result
// waits; the slave side stalls only when both hold results.
// Reset: asynchronous, active low; registers return to threshold 3, start mode
// chase, and the pattern state to position 0 moving right with all LEDs dark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module led_pattern_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] tick, [1] button_level, [7:2] zero
  // Result stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] led_mask, [9:8] mode, [15:10] zero
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [7:0]      threshold_q;
  lps_pkg::mode_e  start_mode_q;

  // Pattern and debounce state
  lps_pkg::state_t state_q;
  lps_pkg::state_t state_d;
  lps_pkg::state_t step_state;

  // Output register and skid entry
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        skid_valid_q;
  logic [15:0] skid_data_q;
  logic [15:0] result;

  logic push;
  logic pop;
  logic cfg_wr;
  logic cfg_wr_mode;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_wr_mode = cfg_wr && (paddr[2] == lps_pkg::REG_START_MODE);

  // Register writes; paddr[1:0] is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= lps_pkg::THRESHOLD_RESET;
      start_mode_q <= lps_pkg::START_MODE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        lps_pkg::REG_DEBOUNCE_THRESHOLD: threshold_q  <= pwdata[7:0];
        lps_pkg::REG_START_MODE:         start_mode_q <= lps_pkg::mode_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lps_pkg::REG_DEBOUNCE_THRESHOLD: prdata = {24'd0, threshold_q};
      lps_pkg::REG_START_MODE:         prdata = {30'd0, start_mode_q};
      default:                         prdata = '0;
    endcase
  end

  // Handshakes: take an item while the skid entry is free
  assign s_axis_tready_o = !skid_valid_q;
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = out_valid_q && m_axis_tready_i;

  lps_step u_step (
    .state_i        (state_q),
    .tick_i         (s_axis_tdata_i[0]),
    .button_level_i (s_axis_tdata_i[1]),
    .threshold_i    (threshold_q),
    .state_o        (step_state)
  );

  assign result = {6'd0, step_state.mode, step_state.led};

  // Advance the state on each transaction; a start mode write loads the mode
  always_comb begin
    state_d = push ? step_state : state_q;
    if (cfg_wr_mode) begin
      state_d.mode = lps_pkg::mode_e'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register with skid: refill from the skid entry first to keep order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        if (push) begin
          skid_data_q <= result;
        end
      end else if (push) begin
        out_data_q <= result;
      end
    end else if (push) begin
      skid_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The skid entry is only ever filled behind a held result
  `ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // The PWM sub-phase never leaves its range
  `ASSERT_ALWAYS(a_pwm_range, clk_i, rst_ni,
                 {1'b0, state_q.pwm} < 4'(lps_pkg::PWM_LEVELS))
  // A latched press always has at least one low sample behind it
  `ASSERT_IMPL(a_latch_has_count, clk_i, rst_ni, state_q.latched, state_q.low_cnt != 8'd0)

endmodule

`default_nettype wire

### hdl/lps_step.sv
// ----------------------------------------------------------------------------
// lps_step
// Next-state logic for one loop pass: pattern step, LED mask, button debounce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lps_step (
  input  lps_pkg::state_t state_i,
  input  logic            tick_i,
  input  logic            button_level_i,
  input  logic [7:0]      threshold_i,
  output lps_pkg::state_t state_o
);

  logic [lps_pkg::POS_W:0]    pos_inc;
  logic [lps_pkg::POS_W-1:0]  pos_wrap;
  logic [lps_pkg::PWM_W:0]    pwm_inc;
  logic [lps_pkg::PWM_W-1:0]  pwm_wrap;
  logic [lps_pkg::POS_W-1:0]  pos_new;
  logic                       dir_new;
  logic [lps_pkg::PWM_W-1:0]  pwm_new;
  logic [lps_pkg::POS_W-1:0]  led_idx;
  logic [lps_pkg::POS_W-1:0]  tri_lvl;
  logic [6:0]                 duty_lhs;
  logic [6:0]                 duty_rhs;
  logic [lps_pkg::MASK_W-1:0] mask_new;
  logic [lps_pkg::CNT_W-1:0]  cnt_sat;

  assign pos_inc  = {1'b0, state_i.position} + 4'd1;
  assign pos_wrap = (pos_inc >= 4'(lps_pkg::NUM_LEDS)) ?
                    3'(pos_inc - 4'(lps_pkg::NUM_LEDS)) : 3'(pos_inc);
  assign pwm_inc  = {1'b0, state_i.pwm} + 4'd1;
  assign pwm_wrap = (pwm_inc >= 4'(lps_pkg::PWM_LEVELS)) ?
                    3'(pwm_inc - 4'(lps_pkg::PWM_LEVELS)) : 3'(pwm_inc);

  // Pattern step in the mode held before the button is handled
  always_comb begin
    pos_new = state_i.position;
    dir_new = state_i.dir_right;
    pwm_new = state_i.pwm;
    case (state_i.mode)
      lps_pkg::MODE_CHASE: begin
        pos_new = pos_wrap;
      end
      lps_pkg::MODE_BOUNCE: begin
        if (state_i.dir_right) begin
          if (state_i.position < 3'(lps_pkg::NUM_LEDS - 1)) begin
            pos_new = 3'(pos_inc);
          end else begin
            pos_new = 3'(lps_pkg::NUM_LEDS - 2);
            dir_new = 1'b0;
          end
        end else begin
          if (state_i.position != 3'd0) begin
            pos_new = state_i.position - 3'd1;
          end else begin
            pos_new = 3'd1;
            dir_new = 1'b1;
          end
        end
      end
      lps_pkg::MODE_BLINK: begin
        pos_new = state_i.position ^ 3'd1;
      end
      default: begin
        pos_new = pos_wrap;
        pwm_new = pwm_wrap;
      end
    endcase
  end

  // Mask from the stepped position; breathe compares pwm < tri*LEVELS/half
  // as (pwm + 1) * half <= tri * LEVELS, which needs no divider.
  assign led_idx = ({1'b0, pos_new} >= 4'(lps_pkg::NUM_LEDS)) ?
                   3'({1'b0, pos_new} - 4'(lps_pkg::NUM_LEDS)) : pos_new;

  always_comb begin
    if ({1'b0, pos_new} <= 4'(lps_pkg::HALF_LEDS)) begin
      tri_lvl = pos_new;
    end else if ({1'b0, pos_new} <= 4'(lps_pkg::NUM_LEDS - 1)) begin
      tri_lvl = 3'(lps_pkg::NUM_LEDS - 1) - pos_new;
    end else begin
      tri_lvl = 3'd0;
    end
  end

  assign duty_lhs = 7'({3'b000, pwm_new} + 7'd1) * 7'(lps_pkg::HALF_LEDS);
  assign duty_rhs = {4'b0000, tri_lvl} * 7'(lps_pkg::PWM_LEVELS);

  always_comb begin
    case (state_i.mode)
      lps_pkg::MODE_CHASE,
      lps_pkg::MODE_BOUNCE:  mask_new = lps_pkg::MASK_W'(8'd1 << led_idx);
      lps_pkg::MODE_BLINK:   mask_new = pos_new[0] ? lps_pkg::LED_ALL : lps_pkg::LED_OFF;
      default:               mask_new = (duty_lhs <= duty_rhs) ?
                                        lps_pkg::LED_ALL : lps_pkg::LED_OFF;
    endcase
  end

  assign cnt_sat = (state_i.low_cnt != lps_pkg::CNT_MAX) ?
                   state_i.low_cnt + 8'd1 : state_i.low_cnt;

  always_comb begin
    state_o = state_i;
    if (tick_i) begin
      state_o.position  = pos_new;
      state_o.dir_right = dir_new;
      state_o.pwm       = pwm_new;
      state_o.led       = mask_new;
    end
    if (!button_level_i) begin
      state_o.low_cnt = cnt_sat;
      if ((cnt_sat >= threshold_i) && !state_i.latched) begin
        state_o.mode    = lps_pkg::mode_e'(state_i.mode + 2'd1);
        state_o.latched = 1'b1;
      end
    end else begin
      state_o.low_cnt = '0;
      state_o.latched = 1'b0;
    end
  end

endmodule

`default_nettype wire

### sim/led_frame_checker.sv
// ----------------------------------------------------------------------------
// led_frame_checker
// Watches the item, result and register channels of the LED pattern
// sequencer, predicts the LED frame of every item and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [0] tick, [1] button_level, [7:2] zero
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] led_mask, [9:8] mode, [15:10] zero
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [lps_pkg::MASK_W-1:0] mask;
    lps_pkg::mode_e             mode;
  } led_frame_t;

  led_frame_t                 led_frames_due[$];
  int                         fail_count;

  logic [7:0]                 threshold_q;
  logic [lps_pkg::POS_W-1:0]  pos_q;
  logic                       dir_right_q;
  lps_pkg::mode_e             mode_q;
  logic [lps_pkg::PWM_W-1:0]  pwm_q;
  logic [lps_pkg::CNT_W-1:0]  low_cnt_q;
  logic                       latched_q;
  logic [lps_pkg::MASK_W-1:0] led_q;

  function automatic logic [lps_pkg::MASK_W-1:0] breathe_mask(
    logic [lps_pkg::POS_W-1:0] pos,
    logic [lps_pkg::PWM_W-1:0] phase
  );
    int tri_level;
    int duty;
    if (pos <= lps_pkg::HALF_LEDS) begin
      tri_level = pos;
    end else if (pos <= lps_pkg::NUM_LEDS - 1) begin
      tri_level = lps_pkg::NUM_LEDS - 1 - pos;
    end else begin
      tri_level = 0;
    end
    duty = tri_level * lps_pkg::PWM_LEVELS / lps_pkg::HALF_LEDS;
    return (int'(phase) < duty) ? lps_pkg::LED_ALL : lps_pkg::LED_OFF;
  endfunction

  // Step the pattern once in the current mode, then refresh the LED register.
  function void step_pattern();
    case (mode_q)
      lps_pkg::MODE_CHASE: begin
        pos_q = lps_pkg::POS_W'((int'(pos_q) + 1) % lps_pkg::NUM_LEDS);
      end
      lps_pkg::MODE_BOUNCE: begin
        if (dir_right_q) begin
          if (pos_q < lps_pkg::NUM_LEDS - 1) begin
            pos_q = pos_q + 1'b1;
          end else begin
            pos_q       = lps_pkg::POS_W'(lps_pkg::NUM_LEDS - 2);
            dir_right_q = 1'b0;
          end
        end else begin
          if (pos_q > 0) begin
            pos_q = pos_q - 1'b1;
          end else begin
            pos_q       = lps_pkg::POS_W'(1);
            dir_right_q = 1'b1;
          end
        end
      end
      lps_pkg::MODE_BLINK: begin
        pos_q = pos_q ^ lps_pkg::POS_W'(1);
      end
      default: begin
        pos_q = lps_pkg::POS_W'((int'(pos_q) + 1) % lps_pkg::NUM_LEDS);
        pwm_q = lps_pkg::PWM_W'((int'(pwm_q) + 1) % lps_pkg::PWM_LEVELS);
      end
    endcase
    case (mode_q)
      lps_pkg::MODE_CHASE, lps_pkg::MODE_BOUNCE:
        led_q = lps_pkg::MASK_W'(1) << (int'(pos_q) % lps_pkg::NUM_LEDS);
      lps_pkg::MODE_BLINK:
        led_q = pos_q[0] ? lps_pkg::LED_ALL : lps_pkg::LED_OFF;
      default:
        led_q = breathe_mask(pos_q, pwm_q);
    endcase
  endfunction

  // Debounce the active-low button; advance the mode once per press.
  function void sample_button(logic level);
    logic [1:0] next_mode;
    if (!level) begin
      if (low_cnt_q < lps_pkg::CNT_MAX) low_cnt_q = low_cnt_q + 1'b1;
      if (low_cnt_q >= threshold_q && !latched_q) begin
        next_mode = mode_q + 2'd1;
        mode_q    = lps_pkg::mode_e'(next_mode);
        latched_q = 1'b1;
      end
    end else begin
      low_cnt_q = '0;
      latched_q = 1'b0;
    end
  endfunction

  function led_frame_t next_led_frame(logic tick, logic level);
    led_frame_t frame;
    if (tick) step_pattern();
    sample_button(level);
    frame.mask = led_q;
    frame.mode = mode_q;
    return frame;
  endfunction

  always @(posedge clk_i) begin : frame_compare
    led_frame_t seen;
    led_frame_t want;
    if (!rst_ni) begin
      threshold_q = lps_pkg::THRESHOLD_RESET;
      pos_q       = '0;
      dir_right_q = 1'b1;
      mode_q      = lps_pkg::START_MODE_RESET;
      pwm_q       = '0;
      low_cnt_q   = '0;
      latched_q   = 1'b0;
      led_q       = lps_pkg::LED_OFF;
      led_frames_due.delete();
    end else begin
      // Compare first, so a stray result never meets this edge's own prediction.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.mask = m_axis_tdata_i[7:0];
        seen.mode = lps_pkg::mode_e'(m_axis_tdata_i[9:8]);
        if (led_frames_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing due: led_mask %02h mode %0d",
                     $realtime, seen.mask, seen.mode);
          fail_count++;
        end else begin
          want = led_frames_due.pop_front();
          if (seen.mask !== want.mask || seen.mode !== want.mode) begin
            if (fail_count < 10)
              $display("%0t: led_mask exp %02h got %02h, mode exp %0d got %0d",
                       $realtime, want.mask, seen.mask, want.mode, seen.mode);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        led_frames_due.push_back(next_led_frame(s_axis_tdata_i[0], s_axis_tdata_i[1]));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          lps_pkg::REG_DEBOUNCE_THRESHOLD: threshold_q = pwdata_i[7:0];
          lps_pkg::REG_START_MODE:         mode_q      = lps_pkg::mode_e'(pwdata_i[1:0]);
          default: ;
        endcase
      end
    end
    pending_o    <= led_frames_due.size();
    fail_count_o <= fail_count;
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression of the LED pattern sequencer: directed button and tick items in
// every mode, then random press sequences under several debounce thresholds
// and start modes, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int MAX_GAP     = 16;

  logic        clk_i;
  logic        rst_ni        = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [0] tick, [1] button_level, [7:2] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] led_mask, [9:8] mode, [15:10] zero

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int          frames_pending;
  int          mismatches;

  // Stretches without idling: each side toggles its calm flag now and then.
  logic        feed_calm  = 1'b0;
  logic        drain_calm = 1'b0;

  // Debounce threshold currently programmed; shapes the press lengths.
  int          threshold_now;

  led_pattern_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  led_frame_checker frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .pending_o       (frames_pending),
    .fail_count_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  initial begin : watchdog
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: hold tready low for a random stall before each transaction.
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) drain_calm = !drain_calm;
      stall = drain_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one button sample after a random gap; return at its transaction.
  task automatic send_sample(input logic tick, input logic level);
    int gap;
    if ($urandom_range(0, 63) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, level, tick};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid and wait until every predicted frame has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (frames_pending != 0);
  endtask

  // One APB write; psel stays high so writes can follow back to back.
  task automatic write_register(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Program threshold and start mode while the block is idle.
  task automatic configure(input int threshold, input lps_pkg::mode_e start);
    drain_results();
    write_register(lps_pkg::REG_DEBOUNCE_THRESHOLD, 32'(threshold));
    write_register(lps_pkg::REG_START_MODE, 32'(start));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    threshold_now = threshold;
  endtask

  // Mostly well-formed presses (release, then a low run around the threshold);
  // the rest is bounce noise and presses cut short.
  task automatic run_presses(input int budget);
    int sent;
    int run_len;
    int reach;
    int k;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        run_len = $urandom_range(1, 8);
        for (k = 0; k < run_len; k++)
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent += run_len;
      end else begin
        reach   = (threshold_now == 0) ? 1 : threshold_now;
        run_len = $urandom_range(1, 4);
        for (k = 0; k < run_len; k++) send_sample(1'($urandom_range(0, 1)), 1'b1);
        sent += run_len;
        if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, reach);
        else run_len = reach + $urandom_range(0, 4);
        for (k = 0; k < run_len; k++) send_sample(1'($urandom_range(0, 1)), 1'b0);
        sent += run_len;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int threshold;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-sample presses walk through every mode.
    configure(1, lps_pkg::MODE_CHASE);
    send_sample(1'b0, 1'b1);          // idle pass, no tick
    repeat (3) send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);          // press without a tick: to bounce
    send_sample(1'b1, 1'b0);          // still held: no second advance
    repeat (2) send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);          // to blink all
    repeat (2) send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);          // to breathe
    repeat (5) send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);          // wrap back to chase
    repeat (2) send_sample(1'b1, 1'b1);

    // Random presses across threshold extremes and the start modes bounce, breathe, blink, then random ones.
    configure(lps_pkg::THRESHOLD_RESET, lps_pkg::MODE_BOUNCE);
    run_presses(300);
    configure(255, lps_pkg::MODE_BREATHE);     // long holds also saturate the count
    run_presses(550);
    configure(0, lps_pkg::MODE_BLINK);         // zero threshold behaves like one
    run_presses(200);
    for (phase = 0; phase < 3; phase++) begin
      threshold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                               : $urandom_range(1, 10);
      configure(threshold, lps_pkg::mode_e'($urandom_range(0, 3)));
      run_presses(150);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/lps_pkg.sv
hdl/lps_step.sv
hdl/led_pattern_sequencer.sv
sim/led_frame_checker.sv
sim/tb.sv
